// ----- rtl/crpi_pkg.sv -----
// ----------------------------------------------------------------------------
// crpi_pkg
// Shared types and constants for the contiguous range page index.
// ----------------------------------------------------------------------------
package crpi_pkg;

	localparam int TABLE_DEPTH  = 1024;
	localparam int ROW_BITS     = 48;
	localparam int PAYLOAD_BITS = 32;
	localparam int IDX_BITS     = $clog2(TABLE_DEPTH);
	localparam int CNT_BITS     = IDX_BITS + 1;

	localparam logic KIND_APPEND = 1'b0;
	localparam logic KIND_FIND   = 1'b1;

	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_GAP  = 2'd1,
		STAT_FULL = 2'd2,
		STAT_MISS = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_PROBE,
		S_COMPARE,
		S_CHECK
	} state_t;

	typedef struct packed {
		logic [ROW_BITS-1:0]     first_row;
		logic [ROW_BITS-1:0]     end_row;
		logic [PAYLOAD_BITS-1:0] payload;
	} entry_t;

endpackage

// ----- rtl/contiguous_range_page_index_top.sv -----
// ----------------------------------------------------------------------------
// contiguous_range_page_index_top
// Table of page row ranges tiling rows from zero; append and binary-search find.
// ----------------------------------------------------------------------------
//  channel   | handshake          | payload
//  ----------+--------------------+---------------------------------------------
//  request   | start, busy        | kind, range_first_row, range_end_row,
//            |                    | page_payload, query_row
//  result    | done (one cycle)   | status, hit_first_row, hit_end_row,
//            |                    | hit_payload, rows_covered, pages_held
//
//  an append raises done in the cycle after start
//  a find runs a binary search over the pages held, each search step a probe
//  that reads the table ram and a compare on the registered entry, then a final
//  probe fetches the candidate entry, which an entry check tests for the hit
//  a find at or past the covered rows, or on an empty table, answers the cycle after start
//  busy is high while a search runs; results cannot be stalled
//  reset clears the counts; the table itself needs no clearing
module contiguous_range_page_index_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              kind,
	input  logic [crpi_pkg::ROW_BITS-1:0]     range_first_row,
	input  logic [crpi_pkg::ROW_BITS-1:0]     range_end_row,
	input  logic [crpi_pkg::PAYLOAD_BITS-1:0] page_payload,
	input  logic [crpi_pkg::ROW_BITS-1:0]     query_row,
	output logic                              done,
	output logic [1:0]                        status,
	output logic [crpi_pkg::ROW_BITS-1:0]     hit_first_row,
	output logic [crpi_pkg::ROW_BITS-1:0]     hit_end_row,
	output logic [crpi_pkg::PAYLOAD_BITS-1:0] hit_payload,
	output logic [crpi_pkg::ROW_BITS-1:0]     rows_covered,
	output logic [crpi_pkg::CNT_BITS-1:0]     pages_held
);

	crpi_pkg::state_t state_q, state_d;

	logic [crpi_pkg::ROW_BITS-1:0] covered_q;
	logic [crpi_pkg::CNT_BITS-1:0] count_q;
	logic                          done_q;

	logic [crpi_pkg::CNT_BITS-1:0] lo_q, hi_q, mid_q, mid;
	logic [crpi_pkg::ROW_BITS-1:0] row_q;

	crpi_pkg::status_t                 status_q;
	logic [crpi_pkg::ROW_BITS-1:0]     hit_first_q, hit_end_q;
	logic [crpi_pkg::PAYLOAD_BITS-1:0] hit_pay_q;

	logic                          accept;
	logic                          app_ok, app_full, find_miss;
	logic                          mem_we, mem_re;
	logic [crpi_pkg::IDX_BITS-1:0] mem_waddr, mem_raddr;
	crpi_pkg::entry_t              wr_entry, rd_entry;
	logic [$bits(crpi_pkg::entry_t)-1:0] rd_data;
	logic                          entry_hit;

	assign accept    = start && (state_q == crpi_pkg::S_IDLE);
	assign app_ok    = (range_first_row == covered_q) && (range_end_row > range_first_row);
	assign app_full  = count_q >= crpi_pkg::CNT_BITS'(crpi_pkg::TABLE_DEPTH);
	assign find_miss = (query_row >= covered_q) || (count_q == '0);
	assign mid       = lo_q + ((hi_q - lo_q) >> 1);
	assign rd_entry  = crpi_pkg::entry_t'(rd_data);
	assign entry_hit = (row_q >= rd_entry.first_row) && (row_q < rd_entry.end_row);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			crpi_pkg::S_IDLE: begin
				if (accept && kind == crpi_pkg::KIND_FIND && !find_miss) begin
					state_d = crpi_pkg::S_PROBE;
				end
			end
			crpi_pkg::S_PROBE: begin
				if (lo_q < hi_q) begin
					state_d = crpi_pkg::S_COMPARE;
				end else if (lo_q == '0) begin
					state_d = crpi_pkg::S_IDLE;
				end else begin
					state_d = crpi_pkg::S_CHECK;
				end
			end
			crpi_pkg::S_COMPARE: state_d = crpi_pkg::S_PROBE;
			crpi_pkg::S_CHECK:   state_d = crpi_pkg::S_IDLE;
			default:             state_d = crpi_pkg::S_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_waddr = count_q[crpi_pkg::IDX_BITS-1:0];
		mem_raddr = mid[crpi_pkg::IDX_BITS-1:0];
		wr_entry  = '{first_row: range_first_row, end_row: range_end_row,
			payload: page_payload};
		case (state_q)
			crpi_pkg::S_IDLE: begin
				mem_we = accept && kind == crpi_pkg::KIND_APPEND && app_ok && !app_full;
			end
			crpi_pkg::S_PROBE: begin
				mem_re = 1'b1;
				// loop over: fetch the last entry starting at or below the row
				if (!(lo_q < hi_q)) begin
					mem_raddr = crpi_pkg::IDX_BITS'(lo_q - 1'b1);
				end
			end
			default: begin
				mem_re = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= crpi_pkg::S_IDLE;
			covered_q <= '0;
			count_q   <= '0;
			done_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			case (state_q)
				crpi_pkg::S_IDLE: begin
					if (accept) begin
						if (kind == crpi_pkg::KIND_APPEND) begin
							done_q <= 1'b1;
							if (app_ok && !app_full) begin
								count_q   <= count_q + 1'b1;
								covered_q <= range_end_row;
							end
						end else if (find_miss) begin
							done_q <= 1'b1;
						end
					end
				end
				crpi_pkg::S_PROBE: begin
					if (!(lo_q < hi_q) && lo_q == '0) begin
						done_q <= 1'b1;
					end
				end
				crpi_pkg::S_CHECK: done_q <= 1'b1;
				default: done_q <= 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			crpi_pkg::S_IDLE: begin
				row_q       <= query_row;
				lo_q        <= '0;
				hi_q        <= count_q;
				hit_first_q <= '0;
				hit_end_q   <= '0;
				hit_pay_q   <= '0;
				if (kind == crpi_pkg::KIND_APPEND) begin
					if (!app_ok) begin
						status_q <= crpi_pkg::STAT_GAP;
					end else if (app_full) begin
						status_q <= crpi_pkg::STAT_FULL;
					end else begin
						status_q <= crpi_pkg::STAT_OK;
					end
				end else begin
					status_q <= crpi_pkg::STAT_MISS;
				end
			end
			crpi_pkg::S_PROBE: begin
				mid_q <= mid;
			end
			crpi_pkg::S_COMPARE: begin
				if (row_q < rd_entry.first_row) begin
					hi_q <= mid_q;
				end else begin
					lo_q <= mid_q + 1'b1;
				end
			end
			crpi_pkg::S_CHECK: begin
				if (entry_hit) begin
					status_q    <= crpi_pkg::STAT_OK;
					hit_first_q <= rd_entry.first_row;
					hit_end_q   <= rd_entry.end_row;
					hit_pay_q   <= rd_entry.payload;
				end else begin
					status_q <= crpi_pkg::STAT_MISS;
				end
			end
			default: begin
				mid_q <= mid_q;
			end
		endcase
	end

	crpi_ram #(
		.DEPTH (crpi_pkg::TABLE_DEPTH),
		.WIDTH ($bits(crpi_pkg::entry_t))
	) u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (wr_entry),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (rd_data)
	);

	assign busy          = state_q != crpi_pkg::S_IDLE;
	assign done          = done_q;
	assign status        = status_q;
	assign hit_first_row = hit_first_q;
	assign hit_end_row   = hit_end_q;
	assign hit_payload   = hit_pay_q;
	assign rows_covered  = covered_q;
	assign pages_held    = count_q;

endmodule

// ----- rtl/crpi_ram.sv -----
// ----------------------------------------------------------------------------
// crpi_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module crpi_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/crpi_chk.sv -----
// ----------------------------------------------------------------------------
// crpi_chk
// Port-level checks for the contiguous range page index, bound to the top.
// ----------------------------------------------------------------------------
module crpi_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              start,
	input logic                              busy,
	input logic                              kind,
	input logic                              done,
	input logic [1:0]                        status,
	input logic [crpi_pkg::ROW_BITS-1:0]     hit_first_row,
	input logic [crpi_pkg::ROW_BITS-1:0]     hit_end_row,
	input logic [crpi_pkg::PAYLOAD_BITS-1:0] hit_payload,
	input logic [crpi_pkg::ROW_BITS-1:0]     rows_covered,
	input logic [crpi_pkg::CNT_BITS-1:0]     pages_held
);

	// an append request answers in the next cycle
	a_append_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && kind == crpi_pkg::KIND_APPEND) |=> (done && !busy))
		else $error("append result not in next cycle");

	// a find request either answers at once or starts a search
	a_find_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && kind == crpi_pkg::KIND_FIND) |=> (busy || done))
		else $error("find request dropped");

	// only a hit carries hit fields
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != crpi_pkg::STAT_OK) |->
		(hit_first_row == '0 && hit_end_row == '0 && hit_payload == '0))
		else $error("hit fields nonzero on non-hit result");

	// table contents change only with an accepted append
	a_count_change: assert property (@(posedge clk) disable iff (!arst_n)
		(!$stable(pages_held) || !$stable(rows_covered)) |->
		(done && status == crpi_pkg::STAT_OK && $past(start && !busy)))
		else $error("count changed without a good append");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pages_held <= crpi_pkg::CNT_BITS'(crpi_pkg::TABLE_DEPTH))
		else $error("page count past table depth");

endmodule

bind contiguous_range_page_index_top crpi_chk u_crpi_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.kind          (kind),
	.done          (done),
	.status        (status),
	.hit_first_row (hit_first_row),
	.hit_end_row   (hit_end_row),
	.hit_payload   (hit_payload),
	.rows_covered  (rows_covered),
	.pages_held    (pages_held)
);

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the contiguous range page index. Requests are driven
// through start/busy and each done strobe is compared against a running
// software copy of the page table: contiguous appends, gap and empty refusals,
// the full table, and binary-search finds over up to every page.
// ----------------------------------------------------------------------------
module tb;
	import crpi_pkg::*;

	typedef logic [ROW_BITS-1:0]     row_t;
	typedef logic [PAYLOAD_BITS-1:0] pay_t;

	typedef struct {
		status_t             stat;
		row_t                first_row;
		row_t                end_row;
		pay_t                payload;
		row_t                covered;
		logic [CNT_BITS-1:0] pages;
	} page_result_t;

	localparam row_t ROW_MAX = '1;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic                kind;
	row_t                range_first_row;
	row_t                range_end_row;
	pay_t                page_payload;
	row_t                query_row;
	logic                done;
	logic [1:0]          status;
	row_t                hit_first_row;
	row_t                hit_end_row;
	pay_t                hit_payload;
	row_t                rows_covered;
	logic [CNT_BITS-1:0] pages_held;

	// software copy of the page table
	row_t page_first [TABLE_DEPTH];
	row_t page_end   [TABLE_DEPTH];
	pay_t page_data  [TABLE_DEPTH];
	row_t rows_total;
	int   page_count;

	page_result_t pending_results[$];
	int           fail_count;
	int           idle_pct;

	contiguous_range_page_index_top DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.kind            (kind),
		.range_first_row (range_first_row),
		.range_end_row   (range_end_row),
		.page_payload    (page_payload),
		.query_row       (query_row),
		.done            (done),
		.status          (status),
		.hit_first_row   (hit_first_row),
		.hit_end_row     (hit_end_row),
		.hit_payload     (hit_payload),
		.rows_covered    (rows_covered),
		.pages_held      (pages_held)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("tb: failure");
		$finish;
	end

	function automatic row_t rand_row();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[ROW_BITS-1:0];
	endfunction

	// mostly short pages, now and then a very long one
	function automatic row_t rand_span();
		int   pick;
		row_t s;
		pick = $urandom_range(19);
		if (pick < 10)
			s = row_t'($urandom_range(8, 1));
		else if (pick < 16)
			s = row_t'($urandom_range(65536, 1));
		else if (pick < 19)
			s = row_t'($urandom_range(32'hffff_ffff, 1));
		else
			s = {8'd0, 8'($urandom_range(255)), 32'($urandom)} + row_t'(1);
		return s;
	endfunction

	function automatic page_result_t index_predict(input logic k, input row_t f, input row_t e,
			input pay_t p, input row_t q);
		page_result_t r;
		int           lo;
		int           hi;
		int           mid;
		r.stat      = STAT_OK;
		r.first_row = '0;
		r.end_row   = '0;
		r.payload   = '0;
		if (k == KIND_APPEND) begin
			if (f != rows_total || e <= f) begin
				r.stat = STAT_GAP;
			end else if (page_count >= TABLE_DEPTH) begin
				r.stat = STAT_FULL;
			end else begin
				page_first[page_count] = f;
				page_end[page_count]   = e;
				page_data[page_count]  = p;
				page_count++;
				rows_total = e;
			end
		end else if (q >= rows_total || page_count == 0) begin
			r.stat = STAT_MISS;
		end else begin
			// lo ends as the number of pages starting at or below the row
			lo = 0;
			hi = page_count;
			while (lo < hi) begin
				mid = (lo + hi) / 2;
				if (q < page_first[mid])
					hi = mid;
				else
					lo = mid + 1;
			end
			if (lo == 0 || q < page_first[lo-1] || q >= page_end[lo-1]) begin
				r.stat = STAT_MISS;
			end else begin
				r.first_row = page_first[lo-1];
				r.end_row   = page_end[lo-1];
				r.payload   = page_data[lo-1];
			end
		end
		r.covered = rows_total;
		r.pages   = page_count[CNT_BITS-1:0];
		return r;
	endfunction

	task automatic issue_request(input logic k, input row_t f, input row_t e, input pay_t p,
			input row_t q);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start <= 1'b0;
			repeat ($urandom_range(15, 1)) @(posedge clk);
		end
		@(negedge clk);
		start           <= 1'b1;
		kind            <= k;
		range_first_row <= f;
		range_end_row   <= e;
		page_payload    <= p;
		query_row       <= q;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_results = {pending_results, index_predict(k, f, e, p, q)};
	endtask

	task automatic append_range(input row_t f, input row_t e, input pay_t p);
		issue_request(KIND_APPEND, f, e, p, rand_row());
	endtask

	task automatic find_row(input row_t q);
		issue_request(KIND_FIND, rand_row(), rand_row(), pay_t'($urandom), q);
	endtask

	// row inside the covered range, leaning toward page edges
	function automatic row_t row_inside();
		int idx;
		idx = $urandom_range(page_count - 1);
		case ($urandom_range(2))
			0: return page_first[idx];
			1: return page_end[idx] - row_t'(1);
			default: return rand_row() % rows_total;
		endcase
	endfunction

	task automatic append_next(input row_t span);
		append_range(rows_total, rows_total + span, pay_t'($urandom));
	endtask

	task automatic test_empty_and_gaps();
		find_row('0);
		find_row(ROW_MAX);
		append_range('0, '0, pay_t'($urandom));
		append_range(row_t'(1), row_t'(5), pay_t'($urandom));
		append_range(ROW_MAX, '0, pay_t'($urandom));
		append_range('0, row_t'(1), '0);
		append_range(row_t'(1), row_t'(3), '1);
		append_range(row_t'(3), row_t'(3), pay_t'($urandom));
		append_range(row_t'(3), row_t'(2), pay_t'($urandom));
		append_range(row_t'(2), row_t'(4), pay_t'($urandom));
		find_row('0);
		find_row(row_t'(1));
		find_row(row_t'(2));
		find_row(row_t'(3));
		find_row(ROW_MAX);
		append_range(row_t'(3), row_t'(3) + (row_t'(1) << 32), pay_t'(32'h5a5a_a5a5));
		find_row((row_t'(1) << 32) + row_t'(2));
		find_row(row_t'(3));
		find_row((row_t'(1) << 32) + row_t'(3));
	endtask

	task automatic test_random_traffic(input int n_items);
		int   pick;
		row_t f;
		for (int i = 0; i < n_items; i++) begin
			if (i % 64 == 0) begin
				case ($urandom_range(2))
					0: idle_pct = 0;
					1: idle_pct = 20;
					default: idle_pct = 50;
				endcase
			end
			pick = $urandom_range(99);
			if (pick < 55 && page_count < TABLE_DEPTH - 64) begin
				append_next(rand_span());
			end else if (pick < 85 || pick < 55) begin
				if (page_count > 0)
					find_row(row_inside());
				else
					find_row(rand_row());
			end else if (pick < 90) begin
				find_row(rand_row());
			end else if (pick < 95) begin
				append_range(rand_row(), rand_row(), pay_t'($urandom));
			end else begin
				// empty or backward range at the covered row
				f = rows_total;
				if (f == '0 || $urandom_range(1) == 0)
					append_range(f, f, pay_t'($urandom));
				else
					append_range(f, rand_row() % f, pay_t'($urandom));
			end
		end
	endtask

	task automatic test_fill_to_capacity();
		idle_pct = 30;
		while (page_count < TABLE_DEPTH) begin
			if ($urandom_range(7) == 0)
				find_row(row_inside());
			append_next(row_t'($urandom_range(4, 1)));
		end
		// valid ranges on a full table, then gap and empty ones, which take precedence
		append_range(rows_total, ROW_MAX, pay_t'($urandom));
		append_range(rows_total, rows_total + row_t'(1), '1);
		append_range(rows_total + row_t'(1), rows_total + row_t'(2), pay_t'($urandom));
		append_range(rows_total, rows_total, pay_t'($urandom));
	endtask

	task automatic test_full_table_finds();
		idle_pct = 0;
		find_row('0);
		find_row(rows_total - row_t'(1));
		find_row(rows_total);
		find_row(ROW_MAX);
		for (int i = 0; i < 80; i++) begin
			case ($urandom_range(9))
				0: find_row(rand_row());
				1: append_next(rand_span());
				2: append_range(rand_row(), rand_row(), pay_t'($urandom));
				default: find_row(row_inside());
			endcase
		end
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : check_result
		page_result_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_results.size() == 0) begin
				fail_count++;
				$display("%0t: result with no request pending, expected none, got status %0d",
					$time, status);
			end else begin
				want = pending_results.pop_front();
				check_field("status", 64'(want.stat), 64'(status));
				check_field("hit_first_row", 64'(want.first_row), 64'(hit_first_row));
				check_field("hit_end_row", 64'(want.end_row), 64'(hit_end_row));
				check_field("hit_payload", 64'(want.payload), 64'(hit_payload));
				check_field("rows_covered", 64'(want.covered), 64'(rows_covered));
				check_field("pages_held", 64'(want.pages), 64'(pages_held));
			end
		end
	end

	initial begin
		int waited;
		arst_n          = 1'b0;
		start           = 1'b0;
		kind            = KIND_APPEND;
		range_first_row = '0;
		range_end_row   = '0;
		page_payload    = '0;
		query_row       = '0;
		rows_total      = '0;
		page_count      = 0;
		fail_count      = 0;
		idle_pct        = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_empty_and_gaps();
		test_random_traffic(1350);
		test_fill_to_capacity();
		test_full_table_finds();

		@(negedge clk);
		start <= 1'b0;
		waited = 0;
		while (pending_results.size() != 0 && waited < 2000) begin
			@(posedge clk);
			waited++;
		end
		repeat (40) @(posedge clk);
		if (pending_results.size() != 0) begin
			fail_count++;
			$display("%0t: %0d requests never answered, expected status %0d, got no result",
				$time, pending_results.size(), pending_results[0].stat);
		end
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
